FILE: rtl/core/iprc_pkg.sv
package iprc_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] PROBE_SRC_PORT_RESET  = 16'd56972;
    localparam logic [15:0] PROBE_BASE_PORT_RESET = 16'd33434;

    localparam int ADDR_FIRST       = 12;
    localparam int ADDR_LAST        = 15;
    localparam int ICMP_HDR_BYTES   = 8;
    localparam int MIN_PROBE_BYTES  = 28;
    localparam int UDP_PORT_BYTES   = 4;

    localparam logic [7:0] ICMP_TYPE_UNREACH  = 8'd3;
    localparam logic [7:0] ICMP_CODE_PORT     = 8'd3;
    localparam logic [7:0] ICMP_TYPE_TIME_EXC = 8'd11;
    localparam logic [7:0] ICMP_CODE_TTL      = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROBE_SRC_PORT  = 1'b0,
        REG_PROBE_BASE_PORT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CLASS_DEST_REACHED = 3'd0,
        CLASS_HOP          = 3'd1,
        CLASS_FOREIGN      = 3'd2,
        CLASS_UNEXPECTED   = 3'd3,
        CLASS_TRUNCATED    = 3'd4
    } reply_class_t;

    typedef struct packed {
        logic [5:0]  outer_hdr;
        logic [5:0]  inner_hdr;
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
        logic [31:0] addr;
        logic [15:0] udp_src;
        logic [15:0] udp_dst;
        logic [7:0]  offset;
    } capture_t;

endpackage

FILE: rtl/core/iprc_if.sv
interface iprc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;
    logic [7:0] expected_port_offset;

    modport source (output valid, output packet_byte, output last_byte,
                    output expected_port_offset, input ready);
    modport sink   (input valid, input packet_byte, input last_byte,
                    input expected_port_offset, output ready);
endinterface

interface iprc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reply_class;
    logic [31:0] responder_address;

    modport source (output valid, output reply_class, output responder_address,
                    input ready);
    modport sink   (input valid, input reply_class, input responder_address,
                    output ready);
endinterface

FILE: rtl/core/iprc_classify.sv
module iprc_classify
(
    input  logic [iprc_pkg::POS_W-1:0] bytes_used,
    input  iprc_pkg::capture_t         cap,
    input  logic [15:0]                probe_src_port,
    input  logic [15:0]                probe_base_port,
    output iprc_pkg::reply_class_t     reply_class
);
    import iprc_pkg::*;

    logic [POS_W-1:0] outer_len;
    logic [POS_W-1:0] min_len;
    logic [POS_W-1:0] payload_len;
    logic [POS_W-1:0] inner_need;
    logic [15:0]      expected_dst;
    logic             is_hop;
    logic             is_dest;
    logic             ports_match;

    assign outer_len    = POS_W'(cap.outer_hdr);
    assign min_len      = outer_len + POS_W'(ICMP_HDR_BYTES);
    assign payload_len  = bytes_used - outer_len;
    assign inner_need   = POS_W'(cap.inner_hdr) + POS_W'(ICMP_HDR_BYTES + UDP_PORT_BYTES);
    assign expected_dst = probe_base_port + 16'(cap.offset);
    assign is_hop       = (cap.msg_type == ICMP_TYPE_TIME_EXC) && (cap.msg_code == ICMP_CODE_TTL);
    assign is_dest      = (cap.msg_type == ICMP_TYPE_UNREACH) && (cap.msg_code == ICMP_CODE_PORT);
    assign ports_match  = (cap.udp_src == probe_src_port) && (cap.udp_dst == expected_dst);

    always_comb
    begin
        if (bytes_used < min_len)
            reply_class = CLASS_TRUNCATED;
        else if (!is_hop && !is_dest)
            reply_class = CLASS_UNEXPECTED;
        else if (payload_len < POS_W'(MIN_PROBE_BYTES) || payload_len < inner_need)
            reply_class = CLASS_TRUNCATED;
        else if (ports_match)
            reply_class = is_hop ? CLASS_HOP : CLASS_DEST_REACHED;
        else
            reply_class = CLASS_FOREIGN;
    end

endmodule

FILE: rtl/core/icmp_probe_reply_classifier.sv
// Classifies a received IPv4 packet as a reply to a UDP traceroute probe. The
// packet arrives one byte per beat, most significant byte first, and a beat
// is taken in every cycle while the result register is empty or being drained.
// Each byte updates the byte count and the captured ICMP type/code, header
// lengths, embedded UDP ports and outer source address; the beat marked last
// registers one result (class and responder address), valid in the next cycle.
// Only the first MAX_PACKET_BYTES bytes of a packet are used. The only stall
// comes from the single result register when its result is not taken.
module icmp_probe_reply_classifier
(
    input  logic                            clk,
    input  logic                            rst_n,
    iprc_in_if.sink                         pkt,
    iprc_out_if.source                      res,
    input  logic                            cfg_we,
    input  logic [iprc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iprc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import iprc_pkg::*;

    logic [15:0]      src_port_cfg_reg;
    logic [15:0]      base_port_cfg_reg;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    capture_t         cap_reg;
    capture_t         cap_next;

    logic             res_valid_reg;
    logic             res_valid_next;
    reply_class_t     class_reg;
    reply_class_t     class_next;
    logic [31:0]      addr_reg;
    logic [31:0]      addr_next;

    logic             accept;
    logic             take;
    logic [POS_W-1:0] bytes_used;
    logic [POS_W-1:0] hdr_pos;
    logic [POS_W-1:0] inner_pos;
    logic [POS_W-1:0] ports_pos;
    capture_t         cur;
    reply_class_t     class_comb;

    assign pkt.ready  = !res_valid_reg || res.ready;
    assign accept     = pkt.valid && pkt.ready;
    assign take       = pos_reg < POS_W'(MAX_PACKET_BYTES);
    assign bytes_used = take ? pos_reg + POS_W'(1) : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_port_cfg_reg  <= PROBE_SRC_PORT_RESET;
            base_port_cfg_reg <= PROBE_BASE_PORT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PROBE_SRC_PORT:  src_port_cfg_reg  <= cfg_data;
                REG_PROBE_BASE_PORT: base_port_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cur = (pos_reg == '0) ? '0 : cap_reg;
        if (pos_reg == '0)
        begin
            cur.offset    = pkt.expected_port_offset;
            cur.outer_hdr = {pkt.packet_byte[3:0], 2'b00};
        end
        if (pos_reg inside {[ADDR_FIRST:ADDR_LAST]})
        begin
            case (pos_reg[1:0])
                2'd0:    cur.addr[31:24] = pkt.packet_byte;
                2'd1:    cur.addr[23:16] = pkt.packet_byte;
                2'd2:    cur.addr[15:8]  = pkt.packet_byte;
                default: cur.addr[7:0]   = pkt.packet_byte;
            endcase
        end
        hdr_pos   = POS_W'(cur.outer_hdr);
        inner_pos = hdr_pos + POS_W'(ICMP_HDR_BYTES);
        if (pos_reg == hdr_pos)
            cur.msg_type = pkt.packet_byte;
        if (pos_reg == hdr_pos + POS_W'(1))
            cur.msg_code = pkt.packet_byte;
        if (pos_reg == inner_pos)
            cur.inner_hdr = {pkt.packet_byte[3:0], 2'b00};
        ports_pos = inner_pos + POS_W'(cur.inner_hdr);
        if (pos_reg == ports_pos)
            cur.udp_src[15:8] = pkt.packet_byte;
        if (pos_reg == ports_pos + POS_W'(1))
            cur.udp_src[7:0] = pkt.packet_byte;
        if (pos_reg == ports_pos + POS_W'(2))
            cur.udp_dst[15:8] = pkt.packet_byte;
        if (pos_reg == ports_pos + POS_W'(3))
            cur.udp_dst[7:0] = pkt.packet_byte;

        cap_next = (accept && take) ? cur : cap_reg;
        pos_next = pos_reg;
        if (accept)
            pos_next = pkt.last_byte ? '0 : bytes_used;
    end

    iprc_classify u_classify
    (
        .bytes_used      (bytes_used),
        .cap             (cap_next),
        .probe_src_port  (src_port_cfg_reg),
        .probe_base_port (base_port_cfg_reg),
        .reply_class     (class_comb)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg && !res.ready;
        class_next     = class_reg;
        addr_next      = addr_reg;
        if (accept && pkt.last_byte)
        begin
            res_valid_next = 1'b1;
            class_next     = class_comb;
            addr_next      = cap_next.addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            cap_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            cap_reg       <= cap_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        class_reg <= class_next;
        addr_reg  <= addr_next;
    end

    assign res.valid             = res_valid_reg;
    assign res.reply_class       = class_reg;
    assign res.responder_address = addr_reg;

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_PACKET_BYTES))
        else $error("byte count past packet limit");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt.valid && pkt.ready && pkt.last_byte) |=> res.valid)
        else $error("last beat gave no result");

    a_middle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt.valid && pkt.ready && !pkt.last_byte) |=> !res.valid)
        else $error("result without last beat");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt.valid && pkt.ready && pkt.last_byte) |=> (pos_reg == '0))
        else $error("byte count not restarted after last beat");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(pkt.valid && pkt.ready && pkt.last_byte))
        else $error("result appeared without a last beat");

endmodule
